// File: hw/rtl/srm_pkg.sv
// Shared types, constants and the sine table generator of the stereo ring/AM modulator.
// Pure package: no dependencies. Used by srm_lane, srm_merge and the top level.
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

    // Defaults of the top level parameters
    localparam int SAMPLE_RATE_HZ_DEF   = 48000;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF      = 24;

    // Fixed widths
    localparam int KNOB_W = 16;   // Q0.16 knob
    localparam int FRAC_W = 24;   // Q0.24 smoothed values and phase
    localparam int SINE_W = 24;   // Q1.23 sine entries
    localparam int FACT_W = 25;   // Q.23 modulation factor, -1.0 .. +1.0
    localparam int FREQ_W = 28;   // carrier frequency, Q.16 Hz

    localparam logic [FRAC_W-1:0] HALF_Q24         = 24'h800000;
    localparam logic [FRAC_W-1:0] DEPTH_OVERSAMPLE = 24'd5872026;
    localparam logic [FREQ_W-1:0] MIN_HZ_Q16       = 28'd13107;
    localparam logic [FREQ_W-1:0] SPAN_HZ_Q16      = 28'd235916493;
    localparam logic [FREQ_W-1:0] OVERSAMPLE_HZ_Q16 = 28'd52428800;
    localparam int SLEW_Q16 = 131;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIME  = 2'd0,
        CFG_DEPTH = 2'd1
    } cfg_index_t;

    // Control from the sequencer to the merging stage
    typedef struct packed {
        logic take;     // lane results valid this cycle
        logic second;   // second tap of the 2x path
        logic dual;     // item runs on the 2x path
    } merge_ctl_t;

    // Sine of entry k of a table with 2^abits entries, Q1.23, by a Taylor series
    // on a quarter wave in Q2.30. Evaluated at elaboration only.
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k,
                                                            input int unsigned abits);
        logic [31:0] ph;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        longint      sum;
        ph   = 32'(k) << (32 - abits);
        quad = ph[31:30];
        r    = {34'd0, ph[29:0]};
        if (quad[0])
            r = 64'd1073741824 - r;
        theta = (r * 64'd1686629713) >> 30;
        t2    = (theta * theta) >> 30;
        sum   = longint'(theta);
        term  = ((theta * t2) >> 30) / 64'd6;
        sum   = sum - longint'(term);
        term  = ((term * t2) >> 30) / 64'd20;
        sum   = sum + longint'(term);
        term  = ((term * t2) >> 30) / 64'd42;
        sum   = sum - longint'(term);
        term  = ((term * t2) >> 30) / 64'd72;
        sum   = sum + longint'(term);
        term  = ((term * t2) >> 30) / 64'd110;
        sum   = sum - longint'(term);
        term  = ((term * t2) >> 30) / 64'd156;
        sum   = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        sum = (sum + 64) >>> 7;
        if (sum > 64'sd8388607)
            sum = 64'sd8388607;
        if (quad[1])
            sum = -sum;
        return SINE_W'(sum);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srm_lane.sv
// One modulation lane: sine ROM lookup with interpolation, depth crossfade, sample scaling.
// Depends on srm_pkg. Instantiated twice (left, right) by the top level.
`timescale 1ns / 1ps
`default_nettype none

module srm_lane #(
    parameter int SAMPLE_BITS      = srm_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = srm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [SAMPLE_BITS-1:0]     x,
    input  wire logic [srm_pkg::FRAC_W-1:0]        phase,
    input  wire logic [srm_pkg::FRAC_W-1:0]        depth,
    output logic signed [SAMPLE_BITS:0]            y,
    output logic                                   done
);
    import srm_pkg::*;

    localparam int ABITS = $clog2(SINE_TABLE_DEPTH);

    typedef logic signed [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            t[k] = sine_entry(k, ABITS);
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    typedef enum logic [2:0] {
        L_IDLE, L_A, L_B, L_C, L_D, L_E
    } lane_state_t;

    lane_state_t                    state_reg;
    logic                           done_reg;
    logic [ABITS-1:0]               idx_reg;
    logic [FRAC_W-1:0]              frac_reg;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic [FRAC_W-1:0]              d_reg;
    logic signed [SINE_W-1:0]       rom_reg;
    logic signed [SINE_W-1:0]       a_reg;
    logic signed [SINE_W-1:0]       c_reg;
    logic signed [FACT_W-1:0]       f_reg;
    logic signed [SAMPLE_BITS:0]    y_reg;

    logic [ABITS-1:0]               rd_addr;
    logic signed [SINE_W:0]         diff;
    logic signed [2*SINE_W+1:0]     interp_prod;
    logic signed [SINE_W-1:0]       c_next;
    logic signed [FACT_W-1:0]       am;
    logic signed [FACT_W:0]         base;
    logic signed [FACT_W:0]         delta;
    logic signed [FACT_W:0]         w;
    logic signed [2*FACT_W+1:0]     lerp_prod;
    logic signed [FACT_W:0]         f_wide;
    logic signed [SAMPLE_BITS+FACT_W-1:0] scale_prod;

    // Second ROM read fetches the neighbor entry, wrapping at the table end
    assign rd_addr = (state_reg == L_B) ? idx_reg + 1'b1 : idx_reg;

    always_comb
    begin
        diff        = SINE_W'(0) + ($signed({rom_reg[SINE_W-1], rom_reg}) -
                                    $signed({a_reg[SINE_W-1], a_reg}));
        interp_prod = (2*SINE_W+2)'(diff) * $signed({2'b0, frac_reg});
        c_next      = SINE_W'(a_reg + SINE_W'(interp_prod >>> FRAC_W));

        am = FACT_W'(($signed({1'b0, HALF_Q24}) + FACT_W'(c_reg)) >>> 1);
        if (d_reg <= HALF_Q24)
        begin
            w     = $signed({1'b0, d_reg, 1'b0});
            base  = $signed({2'b0, HALF_Q24});
            delta = (FACT_W+1)'(am) - $signed({2'b0, HALF_Q24});
        end
        else
        begin
            w     = $signed({1'b0, d_reg - HALF_Q24, 1'b0});
            base  = (FACT_W+1)'(am);
            delta = (FACT_W+1)'(c_reg) - (FACT_W+1)'(am);
        end
        lerp_prod  = (2*FACT_W+2)'(delta) * (2*FACT_W+2)'(w);
        f_wide     = base + (FACT_W+1)'(lerp_prod >>> FRAC_W);
        scale_prod = (SAMPLE_BITS+FACT_W)'(x_reg) * (SAMPLE_BITS+FACT_W)'(f_reg);
    end

    always_ff @(posedge clk)
    begin
        rom_reg <= SINE_ROM[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                        state_reg <= L_A;
                end
                L_A: state_reg <= L_B;
                L_B: state_reg <= L_C;
                L_C: state_reg <= L_D;
                L_D: state_reg <= L_E;
                L_E:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            idx_reg  <= phase[FRAC_W-1 -: ABITS];
            frac_reg <= FRAC_W'({phase[FRAC_W-ABITS-1:0], {ABITS{1'b0}}});
            x_reg    <= x;
            d_reg    <= depth;
        end
        if (state_reg == L_B)
            a_reg <= rom_reg;
        if (state_reg == L_C)
            c_reg <= c_next;
        if (state_reg == L_D)
            f_reg <= FACT_W'(f_wide);
        if (state_reg == L_E)
            y_reg <= (SAMPLE_BITS+1)'(scale_prod >>> 23);
    end

    assign y    = y_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/srm_merge.sv
// Merging stage: combines the lane results of one or two taps, averages and saturates.
// Depends on srm_pkg (merge_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module srm_merge #(
    parameter int SAMPLE_BITS = srm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire srm_pkg::merge_ctl_t            ctl,
    input  wire logic signed [SAMPLE_BITS:0]    y_left,
    input  wire logic signed [SAMPLE_BITS:0]    y_right,
    output logic signed [SAMPLE_BITS-1:0]       out_left,
    output logic signed [SAMPLE_BITS-1:0]       out_right
);
    import srm_pkg::*;

    localparam logic signed [SAMPLE_BITS+1:0] SAT_HI = (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [SAMPLE_BITS+1:0] SAT_LO = -SAT_HI - 1;

    logic signed [SAMPLE_BITS:0]    first_l_reg;
    logic signed [SAMPLE_BITS:0]    first_r_reg;
    logic signed [SAMPLE_BITS-1:0]  res_l_reg;
    logic signed [SAMPLE_BITS-1:0]  res_r_reg;
    logic signed [SAMPLE_BITS+1:0]  comb_l;
    logic signed [SAMPLE_BITS+1:0]  comb_r;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SAMPLE_BITS+1:0] v);
        if (v > SAT_HI)
            return SAMPLE_BITS'(SAT_HI);
        if (v < SAT_LO)
            return SAMPLE_BITS'(SAT_LO);
        return SAMPLE_BITS'(v);
    endfunction

    // Average the midpoint and end taps on the 2x path, else pass the single tap
    always_comb
    begin
        if (ctl.dual)
        begin
            comb_l = ((SAMPLE_BITS+2)'(first_l_reg) + (SAMPLE_BITS+2)'(y_left)) >>> 1;
            comb_r = ((SAMPLE_BITS+2)'(first_r_reg) + (SAMPLE_BITS+2)'(y_right)) >>> 1;
        end
        else
        begin
            comb_l = (SAMPLE_BITS+2)'(y_left);
            comb_r = (SAMPLE_BITS+2)'(y_right);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take && ctl.dual && !ctl.second)
        begin
            first_l_reg <= y_left;
            first_r_reg <= y_right;
        end
        if (ctl.take && (ctl.second || !ctl.dual))
        begin
            res_l_reg <= sat(comb_l);
            res_r_reg <= sat(comb_r);
        end
    end

    assign out_left  = res_l_reg;
    assign out_right = res_r_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stereo_ring_am_modulator_unit.sv
// Each pair is run through the control sequencer and the five-step lane pipeline, once
// or twice per pair (twice on the 2x path); the input is taken only in the idle state, after
// the previous pair has been loaded into the result register.
// The result register frees the input side: a new pair is taken while a result waits.
// Reset (rst_n, async, active low) clears knobs, smoothed values, phase and history.
// Top level of the stereo ring/AM modulator; depends on srm_pkg, srm_lane, srm_merge.
`timescale 1ns / 1ps
`default_nettype none

module stereo_ring_am_modulator_unit #(
    parameter int SAMPLE_RATE_HZ   = srm_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_DEPTH = srm_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = srm_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W          = ((2*SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [srm_pkg::KNOB_W-1:0]    cfg_wdata,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [TDATA_W-1:0]            s_tdata,   // in_left, in_right, zero pad
    // Output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [TDATA_W-1:0]                 m_tdata    // out_left, out_right, zero pad
);
    import srm_pkg::*;

    // Reciprocal of the sample rate for the increment division, with one correction step
    localparam longint unsigned RECIP = (64'd1 << 36) / SAMPLE_RATE_HZ;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int SR_W    = $clog2(SAMPLE_RATE_HZ + 1);
    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
    localparam logic [SR_W-1:0]    SR_C     = SR_W'(SAMPLE_RATE_HZ);
    localparam logic [35:0]        ROUND_C  = 36'(SAMPLE_RATE_HZ / 2);
    localparam int PAD_W = TDATA_W - 2*SAMPLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SLEW, S_T2, S_T4, S_T5, S_FREQ,
        S_DIVA, S_DIVB, S_DIVC, S_TAP, S_WAIT, S_OUT
    } state_t;

    state_t                         state_reg;
    logic [KNOB_W-1:0]              time_tgt_reg;
    logic [KNOB_W-1:0]              depth_tgt_reg;
    logic [FRAC_W-1:0]              ts_reg;
    logic [FRAC_W-1:0]              ds_reg;
    logic [FRAC_W-1:0]              phase_reg;
    logic signed [SAMPLE_BITS-1:0]  prev_l_reg;
    logic signed [SAMPLE_BITS-1:0]  prev_r_reg;
    logic signed [SAMPLE_BITS-1:0]  xl_reg;
    logic signed [SAMPLE_BITS-1:0]  xr_reg;
    logic [FRAC_W-1:0]              pw_reg;      // t^2, then t^4
    logic [FRAC_W-1:0]              t5_reg;
    logic [FREQ_W-1:0]              freq_reg;
    logic [FRAC_W-1:0]              off_reg;
    logic                           dual_reg;
    logic [35:0]                    xd_reg;
    logic [17+RECIP_W:0]            plo_reg;
    logic [17+RECIP_W:0]            phi_reg;
    logic [RECIP_W-1:0]             q0_reg;
    logic [FRAC_W-1:0]              inc_reg;
    logic                           tap_reg;
    logic                           m_tvalid_reg;
    logic [TDATA_W-1:0]             m_tdata_reg;

    logic [FRAC_W-1:0]              ts_next;
    logic [FRAC_W-1:0]              ds_next;
    logic [2*FRAC_W-1:0]            sq_prod;
    logic [FRAC_W+FREQ_W-1:0]       span_prod;
    logic [21:0]                    off_half;
    logic [44:0]                    off_prod;
    logic [35:0]                    xd;
    logic [36+RECIP_W:0]            psum;
    logic [36:0]                    rem;
    logic [RECIP_W+SR_W-1:0]        qsr;
    logic [FRAC_W-1:0]              tap_phase;
    logic [FRAC_W-1:0]              ph_left;
    logic [FRAC_W-1:0]              ph_right;
    logic signed [SAMPLE_BITS-1:0]  lane_xl;
    logic signed [SAMPLE_BITS-1:0]  lane_xr;
    logic signed [SAMPLE_BITS:0]    sum_l;
    logic signed [SAMPLE_BITS:0]    sum_r;
    logic                           lane_start;
    logic signed [SAMPLE_BITS:0]    y_left;
    logic signed [SAMPLE_BITS:0]    y_right;
    logic                           done_left;
    logic                           done_right;
    merge_ctl_t                     mctl;
    logic signed [SAMPLE_BITS-1:0]  res_left;
    logic signed [SAMPLE_BITS-1:0]  res_right;
    logic                           out_free;

    // One-pole slew toward the knob target (Q0.24), rounded step of 131/65536
    function automatic logic [FRAC_W-1:0] slew(input logic [FRAC_W-1:0] s,
                                               input logic [KNOB_W-1:0] knob);
        logic signed [FRAC_W:0]   diff;
        logic signed [33:0]       p;
        logic signed [33:0]       sum;
        diff = $signed({1'b0, knob, 8'd0}) - $signed({1'b0, s});
        p    = 34'(diff) * 34'sd131 + 34'sd32768;
        sum  = $signed({10'd0, s}) + (p >>> 16);
        return sum[FRAC_W-1:0];
    endfunction

    always_comb
    begin
        ts_next = slew(ts_reg, time_tgt_reg);
        ds_next = slew(ds_reg, depth_tgt_reg);

        // Shared 24x24 multiplier for the fifth power chain
        case (state_reg)
            S_T2:    sq_prod = ts_reg * ts_reg;
            S_T4:    sq_prod = pw_reg * pw_reg;
            default: sq_prod = pw_reg * ts_reg;
        endcase
        span_prod = FRAC_W'(t5_reg) * SPAN_HZ_Q16;

        // Stereo offset: (2*(d-0.5))/12 = ((d-0.5)>>1)/3, by reciprocal
        off_half = 22'((ds_reg - HALF_Q24) >> 1);
        off_prod = 45'(off_half) * 45'd2796203;

        xd   = {freq_reg, 8'd0} + ROUND_C;
        psum = (37+RECIP_W)'(plo_reg) + ((37+RECIP_W)'(phi_reg) << 18);
        qsr  = (RECIP_W+SR_W)'(q0_reg) * (RECIP_W+SR_W)'(SR_C);
        rem  = 37'(xd_reg) - 37'(qsr);

        // Tap selection: single tap at the current phase, or midpoint then end on the 2x path
        sum_l = (SAMPLE_BITS+1)'(prev_l_reg) + (SAMPLE_BITS+1)'(xl_reg);
        sum_r = (SAMPLE_BITS+1)'(prev_r_reg) + (SAMPLE_BITS+1)'(xr_reg);
        if (dual_reg && !tap_reg)
        begin
            tap_phase = phase_reg + (inc_reg >> 1);
            lane_xl   = SAMPLE_BITS'(sum_l >>> 1);
            lane_xr   = SAMPLE_BITS'(sum_r >>> 1);
        end
        else if (dual_reg)
        begin
            tap_phase = phase_reg + inc_reg;
            lane_xl   = xl_reg;
            lane_xr   = xr_reg;
        end
        else
        begin
            tap_phase = phase_reg;
            lane_xl   = xl_reg;
            lane_xr   = xr_reg;
        end
        // Left phase moves back, right phase forward
        ph_left  = tap_phase - off_reg;
        ph_right = tap_phase + off_reg;
    end

    assign lane_start  = (state_reg == S_TAP);
    assign mctl.take   = (state_reg == S_WAIT) && done_left;
    assign mctl.second = tap_reg;
    assign mctl.dual   = dual_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_tgt_reg  <= '0;
            depth_tgt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME:  time_tgt_reg  <= cfg_wdata;
                CFG_DEPTH: depth_tgt_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Sequencer with item state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ts_reg       <= '0;
            ds_reg       <= '0;
            phase_reg    <= '0;
            prev_l_reg   <= '0;
            prev_r_reg   <= '0;
            tap_reg      <= 1'b0;
            dual_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result after its transfer unless a new one loads in the same cycle
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_SLEW;
                end
                S_SLEW:
                begin
                    ts_reg    <= ts_next;
                    ds_reg    <= ds_next;
                    state_reg <= S_T2;
                end
                S_T2:   state_reg <= S_T4;
                S_T4:   state_reg <= S_T5;
                S_T5:   state_reg <= S_FREQ;
                S_FREQ:
                begin
                    dual_reg  <= 1'b0;
                    state_reg <= S_DIVA;
                end
                S_DIVA:
                begin
                    dual_reg  <= (freq_reg >= OVERSAMPLE_HZ_Q16) && (ds_reg > DEPTH_OVERSAMPLE);
                    state_reg <= S_DIVB;
                end
                S_DIVB: state_reg <= S_DIVC;
                S_DIVC:
                begin
                    tap_reg   <= 1'b0;
                    state_reg <= S_TAP;
                end
                S_TAP:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (done_left)
                    begin
                        if (dual_reg && !tap_reg)
                        begin
                            tap_reg   <= 1'b1;
                            state_reg <= S_TAP;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        phase_reg    <= phase_reg + inc_reg;
                        prev_l_reg   <= xl_reg;
                        prev_r_reg   <= xr_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            xl_reg <= s_tdata[SAMPLE_BITS-1:0];
            xr_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (state_reg == S_T2 || state_reg == S_T4)
            pw_reg <= sq_prod[2*FRAC_W-1:FRAC_W];
        if (state_reg == S_T5)
            t5_reg <= sq_prod[2*FRAC_W-1:FRAC_W];
        if (state_reg == S_FREQ)
        begin
            freq_reg <= MIN_HZ_Q16 + span_prod[FRAC_W+FREQ_W-1:FRAC_W];
            off_reg  <= (ds_reg > HALF_Q24) ? FRAC_W'(off_prod >> 23) : '0;
        end
        if (state_reg == S_DIVA)
        begin
            xd_reg  <= xd;
            plo_reg <= (18+RECIP_W)'(xd[17:0]) * (18+RECIP_W)'(RECIP_C);
            phi_reg <= (18+RECIP_W)'(xd[35:18]) * (18+RECIP_W)'(RECIP_C);
        end
        if (state_reg == S_DIVB)
            q0_reg <= psum[36 +: RECIP_W];
        if (state_reg == S_DIVC)
            inc_reg <= (rem >= 37'(SR_C)) ? FRAC_W'(q0_reg + 1'b1) : FRAC_W'(q0_reg);
        if (state_reg == S_OUT && out_free)
        begin
            if (PAD_W > 0)
                m_tdata_reg <= TDATA_W'({res_right, res_left});
            else
                m_tdata_reg <= TDATA_W'({res_right, res_left});
        end
    end

    srm_lane #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .x     (lane_xl),
        .phase (ph_left),
        .depth (ds_reg),
        .y     (y_left),
        .done  (done_left)
    );

    srm_lane #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .x     (lane_xr),
        .phase (ph_right),
        .depth (ds_reg),
        .y     (y_right),
        .done  (done_right)
    );

    srm_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk       (clk),
        .ctl       (mctl),
        .y_left    (y_left),
        .y_right   (y_right),
        .out_left  (res_left),
        .out_right (res_right)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_left == done_right)
        else $error("lane results out of step");

    // Lane results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        done_left |-> state_reg == S_WAIT)
        else $error("lane result outside wait state");

    // A second tap is started only on the 2x path
    a_second_tap_dual: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP && tap_reg) |-> dual_reg)
        else $error("second tap without 2x path");

    // Result valid rises only after the sequencer has been in the output state
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire

// File: dv/tb_stereo_ring_am_modulator_unit.sv
// Self-checking testbench of the stereo ring/AM modulator top level.
// Depends on srm_pkg and the RTL of stereo_ring_am_modulator_unit; it stands alone otherwise.
`timescale 1ns / 1ps

module tb_stereo_ring_am_modulator_unit;
    import srm_pkg::*;

    localparam int     SB          = 24;
    localparam int     TW          = 48;
    localparam int     TAB_DEPTH   = 1024;
    localparam longint RATE_HZ     = 48000;
    localparam longint Q24_ONE     = 64'sd16777216;
    localparam longint Q24_MASK    = 64'sd16777215;
    localparam longint Q23_ONE     = 64'sd8388608;
    localparam longint SAMPLE_MAX  = 64'sd8388607;
    localparam longint CYCLE_LIMIT = 2000000;
    // index past the end of the register list; writes there must do nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SB-1:0] right;
        logic signed [SB-1:0] left;   // lowest bits
    } pair_t;

    typedef struct {
        bit                   wr;     // rewrite the knobs before this row
        logic [15:0]          kt;
        logic [15:0]          kd;
        bit                   spare;  // also poke the unused register index
        logic signed [SB-1:0] l;
        logic signed [SB-1:0] r;
        bit                   known;  // depth still zero: output is the input
    } row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = CFG_TIME;
    logic [15:0]     cfg_wdata = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [TW-1:0]   s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [TW-1:0]   m_tdata;

    // shadow state of the modulator
    logic [15:0]     knob_time, knob_depth;
    longint          smooth_time, smooth_depth, carrier_acc, hist_l, hist_r;
    longint          sine_rom[TAB_DEPTH];

    pair_t           modulated_q[$];
    int              errors = 0;
    int              pairs_seen = 0;
    int              hold_left = 0;
    bit              hold_done = 0;
    longint          cycles = 0;

    stereo_ring_am_modulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // in_left, in_right
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // out_left, out_right
    );

    always #1 clk = ~clk;

    // Abort on a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL stereo_ring_am_modulator_unit");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // Quarter-wave Taylor series in Q2.30, rounded to Q1.23.
    function automatic longint taylor_sine(input logic [31:0] ph);
        logic [63:0] r, theta, t2, term;
        longint      sum;
        r = {34'd0, ph[29:0]};
        if (ph[30])
            r = 64'd1073741824 - r;
        theta = (r * 64'd1686629713) >> 30;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        sum = (sum + 64) >>> 7;
        if (sum > SAMPLE_MAX)
            sum = SAMPLE_MAX;
        return ph[31] ? -sum : sum;
    endfunction

    // Interpolated carrier at a 24-bit phase.
    function automatic longint carrier(input longint p);
        longint prod, idx, frac, a, b;
        prod = (p & Q24_MASK) * TAB_DEPTH;
        idx  = prod >>> 24;
        frac = prod & Q24_MASK;
        a    = sine_rom[idx];
        b    = sine_rom[(idx + 1) % TAB_DEPTH];
        return a + (((b - a) * frac) >>> 24);
    endfunction

    // Dry -> AM -> ring crossfade of the gain; all terms kept signed.
    function automatic longint gain(input longint c, input longint d);
        longint am, half;
        half = longint'(HALF_Q24);
        am   = (Q23_ONE + c) >>> 1;
        if (d <= half)
            return Q23_ONE + (((am - Q23_ONE) * (d * 2)) >>> 24);
        return am + (((c - am) * ((d - half) * 2)) >>> 24);
    endfunction

    function automatic longint mod_sample(input longint x, input longint p, input longint off,
                                          input longint d, input bit right);
        longint q;
        q = right ? ((p + off) & Q24_MASK) : ((p + Q24_ONE - off) & Q24_MASK);
        return (x * gain(carrier(q), d)) >>> 23;
    endfunction

    function automatic logic [SB-1:0] clip(input longint v);
        if (v > SAMPLE_MAX)
            return SB'(SAMPLE_MAX);
        if (v < -SAMPLE_MAX - 1)
            return SB'(-SAMPLE_MAX - 1);
        return SB'(v);
    endfunction

    function automatic longint slew(input longint s, input logic [15:0] knob);
        return s + (((longint'(knob) * 256 - s) * SLEW_Q16 + 32768) >>> 16);
    endfunction

    // Advance the shadow state by one pair and return the modulated pair.
    task automatic modulate_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                                 output pair_t res);
        longint t2, t4, t5, freq, inc, off, d, xl, xr, ml, mr, pm, pe, ol, orr;
        smooth_time  = slew(smooth_time, knob_time);
        smooth_depth = slew(smooth_depth, knob_depth);
        t2   = (smooth_time * smooth_time) >>> 24;
        t4   = (t2 * t2) >>> 24;
        t5   = (t4 * smooth_time) >>> 24;
        freq = 64'(MIN_HZ_Q16) + ((t5 * 64'(SPAN_HZ_Q16)) >>> 24);
        inc  = (freq * 256 + RATE_HZ / 2) / RATE_HZ;
        d    = smooth_depth;
        off  = (d > 64'(HALF_Q24)) ? ((d - 64'(HALF_Q24)) * 2) / 12 : 0;
        xl   = longint'(l);
        xr   = longint'(r);
        if (freq >= 64'(OVERSAMPLE_HZ_Q16) && d > 64'(DEPTH_OVERSAMPLE))
        begin
            // 2x path: midpoint tap and end tap, averaged
            ml  = (hist_l + xl) >>> 1;
            mr  = (hist_r + xr) >>> 1;
            pm  = (carrier_acc + (inc >>> 1)) & Q24_MASK;
            pe  = (carrier_acc + inc) & Q24_MASK;
            ol  = (mod_sample(ml, pm, off, d, 0) + mod_sample(xl, pe, off, d, 0)) >>> 1;
            orr = (mod_sample(mr, pm, off, d, 1) + mod_sample(xr, pe, off, d, 1)) >>> 1;
        end
        else
        begin
            ol  = mod_sample(xl, carrier_acc, off, d, 0);
            orr = mod_sample(xr, carrier_acc, off, d, 1);
        end
        res.left    = clip(ol);
        res.right   = clip(orr);
        hist_l      = xl;
        hist_r      = xr;
        carrier_acc = (carrier_acc + inc) & Q24_MASK;
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SB'($urandom_range(0, 15)) - 24'd8;
            default: return SB'($urandom);
        endcase
    endfunction

    // Write one register; only called with nothing in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_TIME)
            knob_time = val;
        else if (idx == CFG_DEPTH)
            knob_depth = val;
    endtask

    // Drain all results, then rewrite both knobs.
    task automatic set_knobs(input logic [15:0] kt, input logic [15:0] kd);
        while (modulated_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_TIME, kt);
        write_reg(CFG_DEPTH, kd);
    endtask

    // Offer one pair and hold it until the transfer; predict on acceptance.
    task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                             input int gap, output pair_t res);
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        modulate_pair(l, r, res);
        modulated_q.push_back(res);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink side: check every result transfer, stall at random, one long hold-off.
    always @(posedge clk)
    begin
        pair_t want, got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = pair_t'(m_tdata);
                pairs_seen++;
                if (modulated_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = modulated_q.pop_front();
                    if (got.left !== want.left)
                        report($sformatf("out_left %0d, want %0d", got.left, want.left));
                    if (got.right !== want.right)
                        report($sformatf("out_right %0d, want %0d", got.right, want.right));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && pairs_seen == 300)
            begin
                // hold off long enough to back the block up into its input
                hold_done <= 1'b1;
                hold_left <= 400;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) < 70) || (pairs_seen % 256 < 40);
        end
    end

    initial
    begin
        row_t        plan[14];
        pair_t       res;
        logic [15:0] ph_kt[6];
        logic [15:0] ph_kd[6];
        int          ph_len[6];
        bit          burst;

        plan = '{
            '{1, 16'h0000, 16'h0000, 0, 24'sh7FFFFF, 24'sh800000, 1},
            '{0, 16'h0000, 16'h0000, 0, 24'sh800000, 24'sh7FFFFF, 1},
            '{0, 16'h0000, 16'h0000, 0, 24'sh000000, 24'shFFFFFF, 1},
            '{0, 16'h0000, 16'h0000, 0, 24'shFFFFFF, 24'sh000000, 1},
            '{1, 16'h0000, 16'h0000, 1, 24'sh000001, 24'shFFFFFF, 1},
            '{1, 16'hFFFF, 16'hFFFF, 0, 24'sh7FFFFF, 24'sh800000, 0},
            '{0, 16'hFFFF, 16'hFFFF, 0, 24'sh800000, 24'sh800000, 0},
            '{0, 16'hFFFF, 16'hFFFF, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0},
            '{0, 16'hFFFF, 16'hFFFF, 0, 24'sh000000, 24'sh000000, 0},
            '{1, 16'h8000, 16'h8000, 0, 24'sh800000, 24'sh7FFFFF, 0},
            '{0, 16'h8000, 16'h8000, 0, 24'sh000001, 24'shFFFFFE, 0},
            '{1, 16'hFFFF, 16'h0000, 0, 24'sh7FFFFF, 24'sh800000, 0},
            '{1, 16'h0000, 16'hFFFF, 0, 24'sh800000, 24'sh800000, 0},
            '{0, 16'h0000, 16'hFFFF, 0, 24'sh7FFFFF, 24'sh000000, 0}
        };
        // long full-scale phase first so the 2x path is reached
        ph_kt  = '{16'hFFFF, 16'hC000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000};
        ph_kd  = '{16'hFFFF, 16'hB000, 16'h5000, 16'hFFFF, 16'h0000, 16'h0000};
        ph_len = '{900, 200, 200, 200, 200, 250};

        for (int k = 0; k < TAB_DEPTH; k++)
            sine_rom[k] = taylor_sine(32'(k) << 22);
        knob_time    = '0;
        knob_depth   = '0;
        smooth_time  = 0;
        smooth_depth = 0;
        carrier_acc  = 0;
        hist_l       = 0;
        hist_r       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                s_tvalid <= 1'b0;
                set_knobs(plan[i].kt, plan[i].kd);
                if (plan[i].spare)
                    write_reg(CFG_SPARE, 16'hFFFF);
            end
            send_pair(plan[i].l, plan[i].r, (i % 3 == 0) ? 0 : pick_gap(), res);
            if (plan[i].known && (res.left !== plan[i].l || res.right !== plan[i].r))
                report($sformatf("row %0d: depth zero does not pass the input", i));
        end

        // random phases
        for (int p = 0; p < 6; p++)
        begin
            s_tvalid <= 1'b0;
            if (p == 5)
                set_knobs(16'($urandom), 16'($urandom));
            else
                set_knobs(ph_kt[p], ph_kd[p]);
            burst = 0;
            for (int n = 0; n < ph_len[p]; n++)
            begin
                if (n % 64 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                send_pair(rand_sample(), rand_sample(), burst ? 0 : pick_gap(), res);
            end
        end
        s_tvalid <= 1'b0;

        while (modulated_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS stereo_ring_am_modulator_unit");
        else
            $display("FAIL stereo_ring_am_modulator_unit");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/srm_pkg.sv
hw/rtl/srm_lane.sv
hw/rtl/srm_merge.sv
hw/rtl/stereo_ring_am_modulator_unit.sv
dv/tb_stereo_ring_am_modulator_unit.sv
